FILE: hdl/qaed_pkg.sv
// qaed_pkg: shared types, codes and helpers for the query argument extractor
// depends on nothing; imported by every module of the block
`default_nettype none

package qaed_pkg;

    // parser modes
    localparam logic [2:0] MODE_SEG   = 3'd0;
    localparam logic [2:0] MODE_MATCH = 3'd1;
    localparam logic [2:0] MODE_SKIP  = 3'd2;
    localparam logic [2:0] MODE_VALUE = 3'd3;
    localparam logic [2:0] MODE_DONE  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_CHARS    = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
    localparam logic [1:0] REG_OUT_CAPACITY = 2'd2;

    localparam logic [8:0] CAPACITY_RESET = 9'd64;
    localparam logic [8:0] CAPACITY_MAX   = 9'd256;

    // characters
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_LF      = 8'h0a;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [8:0] length;
        logic       truncated;
        logic       last;
    } result_t;

    // results raised by one input beat, in delivery order
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } result_pair_t;

    typedef struct packed {
        logic [FIFO_AW:0] level;
    } fifo_status_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/qaed_parse.sv
// qaed_parse: scan state registers and the per-beat segment, key and
// percent-decode logic; depends on qaed_pkg
`default_nettype none

module qaed_parse
    import qaed_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic [7:0]                   in_byte,
    input  wire logic                         in_last,
    input  wire logic [8*MAX_KEY_BYTES-1:0]   key_chars,
    input  wire logic [3:0]                   key_length,
    input  wire logic [8:0]                   out_capacity,
    output result_pair_t                      results,
    output logic [2:0]                        mode
);

    logic [2:0] mode_reg, mode_next;
    logic [3:0] key_pos_reg, key_pos_next;
    logic [1:0] esc_reg, esc_next;
    logic [3:0] nibble_reg, nibble_next;
    logic [8:0] count_reg, count_next;
    logic       ovf_reg, ovf_next;

    logic [3:0] klen;
    logic [8:0] cap_m1;
    logic [7:0] key_char;
    result_t    res_a, res_b;
    logic       a_valid, b_valid;

    assign klen = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;

    always_comb begin
        if (out_capacity == 9'd0) cap_m1 = 9'd0;
        else if (out_capacity > CAPACITY_MAX) cap_m1 = CAPACITY_MAX - 9'd1;
        else cap_m1 = out_capacity - 9'd1;
    end

    always_comb begin
        key_char = 8'd0;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (key_pos_reg == 4'(i)) key_char = key_chars[8*i +: 8];
        end
    end

    always_comb begin
        logic [2:0] m;
        m = mode_reg;
        key_pos_next = key_pos_reg;
        esc_next     = esc_reg;
        nibble_next  = nibble_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        a_valid      = 1'b0;
        b_valid      = 1'b0;
        res_a        = '0;
        res_b        = '0;

        if (in_byte != 8'd0) begin
            if (m == MODE_SEG) begin
                if (in_byte == CHAR_CR || in_byte == CHAR_LF) begin
                    a_valid    = 1'b1;
                    res_a.kind = KIND_NOT_FOUND;
                    m          = MODE_DONE;
                end else begin
                    m            = MODE_MATCH;
                    key_pos_next = 4'd0;
                end
            end
            if (m == MODE_MATCH) begin
                // key_position is cleared on entry from segment start
                if (((mode_reg == MODE_SEG) ? 4'd0 : key_pos_reg) < klen) begin
                    if (in_byte == ((mode_reg == MODE_SEG) ? key_chars[7:0] : key_char)) begin
                        key_pos_next = ((mode_reg == MODE_SEG) ? 4'd0 : key_pos_reg) + 4'd1;
                    end else if (in_byte == CHAR_AMP) begin
                        m            = MODE_SEG;
                        key_pos_next = 4'd0;
                    end else begin
                        m = MODE_SKIP;
                    end
                end else if (in_byte == CHAR_EQUALS) begin
                    m          = MODE_VALUE;
                    esc_next   = 2'd0;
                    count_next = 9'd0;
                    ovf_next   = 1'b0;
                end else if (in_byte == CHAR_AMP) begin
                    m            = MODE_SEG;
                    key_pos_next = 4'd0;
                end else begin
                    m = MODE_SKIP;
                end
            end else if (m == MODE_SKIP) begin
                if (in_byte == CHAR_AMP) begin
                    m            = MODE_SEG;
                    key_pos_next = 4'd0;
                end
            end else if (m == MODE_VALUE) begin
                if (in_byte == CHAR_AMP) begin
                    a_valid          = 1'b1;
                    res_a.kind       = KIND_FOUND;
                    res_a.length     = count_reg + 9'd1;
                    res_a.truncated  = ovf_reg;
                    m                = MODE_DONE;
                end else if (count_reg >= cap_m1) begin
                    ovf_next = 1'b1;
                end else if (esc_reg == 2'd1) begin
                    nibble_next = hex_value(in_byte);
                    esc_next    = 2'd2;
                end else if (esc_reg == 2'd2) begin
                    a_valid    = 1'b1;
                    res_a.kind = KIND_BYTE;
                    res_a.data = {nibble_reg, hex_value(in_byte)};
                    count_next = count_reg + 9'd1;
                    esc_next   = 2'd0;
                end else if (in_byte == CHAR_PERCENT) begin
                    esc_next = 2'd1;
                end else begin
                    a_valid    = 1'b1;
                    res_a.kind = KIND_BYTE;
                    res_a.data = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;
                    count_next = count_reg + 9'd1;
                end
            end
        end

        if (in_byte == 8'd0 || in_last) begin
            if (m == MODE_VALUE) begin
                b_valid         = 1'b1;
                res_b.kind      = KIND_FOUND;
                res_b.length    = count_next + 9'd1;
                res_b.truncated = ovf_next;
            end else if (m != MODE_DONE) begin
                b_valid    = 1'b1;
                res_b.kind = KIND_NOT_FOUND;
            end
            m            = MODE_SEG;
            key_pos_next = 4'd0;
            esc_next     = 2'd0;
            nibble_next  = 4'd0;
            count_next   = 9'd0;
            ovf_next     = 1'b0;
        end
        mode_next = m;
    end

    // pack the two possible results in order, marking the final one
    always_comb begin
        results              = '0;
        results.first_valid  = a_valid | b_valid;
        results.second_valid = a_valid & b_valid;
        results.first        = a_valid ? res_a : res_b;
        results.first.last   = ~(a_valid & b_valid);
        results.second       = res_b;
        results.second.last  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_SEG;
            key_pos_reg <= 4'd0;
            esc_reg     <= 2'd0;
            nibble_reg  <= 4'd0;
            count_reg   <= 9'd0;
            ovf_reg     <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            key_pos_reg <= key_pos_next;
            esc_reg     <= esc_next;
            nibble_reg  <= nibble_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign mode = mode_reg;

endmodule

`default_nettype wire

FILE: hdl/qaed_out_fifo.sv
// qaed_out_fifo: four-entry result queue taking up to two results a beat
// and giving one a cycle while pop is high; depends on qaed_pkg
`default_nettype none

module qaed_out_fifo
    import qaed_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire result_pair_t push_data,
    input  wire logic   pop,
    output result_t     head,
    output logic        head_valid,
    output logic        room_for_pair,
    output fifo_status_t status
);

    result_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   level_reg, level_next;
    logic [FIFO_AW:0]   n_push;
    logic               do_pop;

    assign do_pop = pop & (level_reg != '0);
    assign n_push = push ? ((FIFO_AW+1)'(push_data.first_valid)
                          + (FIFO_AW+1)'(push_data.second_valid)) : '0;
    assign level_next = level_reg + n_push - (FIFO_AW+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (push && push_data.first_valid) entry_reg[wr_ptr_reg] <= push_data.first;
        if (push && push_data.second_valid)
            entry_reg[wr_ptr_reg + FIFO_AW'(1)] <= push_data.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push[FIFO_AW-1:0];
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(do_pop);
            level_reg  <= level_next;
        end
    end

    assign head          = entry_reg[rd_ptr_reg];
    assign head_valid    = level_reg != '0;
    assign room_for_pair = level_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign status.level  = level_reg;

endmodule

`default_nettype wire

FILE: hdl/query_argument_extract_decode.sv
// query_argument_extract_decode: top level, configuration registers, parser
// and result queue; depends on qaed_pkg, qaed_parse, qaed_out_fifo
`default_nettype none
//
//  channel   dir  beat carries
//  s_        in   tdata[7:0] in_byte, tlast in_last
//  m_        out  tdata[7:0] out_byte, [16:8] out_length, [17] truncated;
//                 tuser[1:0] result_kind; tlast run_last
//  cfg_      in   index 0 key_chars, 1 key_length, 2 out_capacity
//
//  one input beat is parsed in the cycle it is accepted; its zero, one or two
//  results enter a four-entry queue and leave one per cycle while m_tready
//  is high; s_tready is high while the queue holds at most two results, so
//  with m_tready high a stream raising one result a beat runs at one beat per
//  cycle, and a beat raising two results grows the queue by one
//  reset clears parser state and the queue; key is zero, capacity 64

module query_argument_extract_decode
    import qaed_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_byte, out_length, truncated, zero pad
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    logic [8*MAX_KEY_BYTES-1:0] key_chars_reg;
    logic [3:0]                 key_length_reg;
    logic [8:0]                 capacity_reg;

    logic         s_accept;
    result_pair_t pair;
    result_t      head;
    fifo_status_t fifo_status;
    logic [2:0]   parse_mode;
    logic         room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_chars_reg  <= '0;
            key_length_reg <= 4'd0;
            capacity_reg   <= CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY_CHARS:    key_chars_reg  <= cfg_wdata[8*MAX_KEY_BYTES-1:0];
                REG_KEY_LENGTH:   key_length_reg <= cfg_wdata[3:0];
                REG_OUT_CAPACITY: capacity_reg   <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign s_tready = room;
    assign s_accept = s_tvalid & room;

    qaed_parse #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .key_chars    (key_chars_reg),
        .key_length   (key_length_reg),
        .out_capacity (capacity_reg),
        .results      (pair),
        .mode         (parse_mode)
    );

    qaed_out_fifo u_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (s_accept),
        .push_data     (pair),
        .pop           (m_tready),
        .head          (head),
        .head_valid    (m_tvalid),
        .room_for_pair (room),
        .status        (fifo_status)
    );

    assign m_tdata = {6'd0, head.truncated, head.length, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.level <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // input is only taken with room for two results
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> fifo_status.level <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
        else $error("input ready without room for a result pair");

    // a final beat returns the parser to segment start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> parse_mode == MODE_SEG)
        else $error("parser not back at segment start after final beat");

    // a second result always follows a first one
    assert property (@(posedge aclk) disable iff (!aresetn)
        pair.second_valid |-> pair.first_valid && !pair.first.last)
        else $error("result pair badly ordered");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for query_argument_extract_decode, a directed table
// then random query strings over several register settings, checked beat by beat
// depends on qaed_pkg and the rtl top level only

module tb_top;
    import qaed_pkg::*;

    localparam int MAX_KEY      = 8;
    localparam int NROWS        = 32;
    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 50;
    localparam int CALM_PHASE   = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int IDLE_BOUND   = 20000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        result_t    want;
    } beat_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [63:0] val;
        beat_t       beat;
    } row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // in_byte
    logic        s_tlast   = 1'b0;   // in_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // out_byte, out_length, truncated, zero pad
    logic [1:0]  m_tuser;            // result_kind
    logic        m_tlast;            // run_last
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_wdata = 64'd0;

    query_argument_extract_decode u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the registers and of the parser state
    logic [63:0] key_cfg  = 64'd0;
    logic [3:0]  klen_cfg = 4'd0;
    logic [8:0]  cap_cfg  = CAPACITY_RESET;
    logic [2:0]  p_mode   = MODE_SEG;
    logic [3:0]  p_kpos   = 4'd0;
    logic [1:0]  p_esc    = 2'd0;
    logic [3:0]  p_hi     = 4'd0;
    logic [8:0]  p_count  = 9'd0;
    logic        p_ovf    = 1'b0;

    result_t step_out [2];
    int      step_n;

    beat_t   beat_q [$];
    result_t awaited_results [$];
    beat_t   cur_beat;
    logic    s_taken   = 1'b0;
    bit      calm      = 1'b0;
    bit      hold_req  = 1'b0;
    int      hold_left = 0;

    int errors      = 0;
    int n_beats     = 0;
    int n_queued    = 0;
    int n_results   = 0;
    int n_found     = 0;
    int n_not_found = 0;
    int n_writes    = 0;
    int cycle_count = 0;

    row_t dir_table [NROWS];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("query_argument_extract_decode test failed");
        $finish;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c[3:0];
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66) return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [8:0] len, input logic trunc);
        result_t r;
        r.kind      = kind;
        r.data      = data;
        r.length    = len;
        r.truncated = trunc;
        r.last      = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endfunction

    // advances the bench parser by one beat and leaves its results in step_out
    function automatic void decode_beat(input logic [7:0] ch, input logic fin);
        logic [3:0] klen;
        logic [8:0] cap;
        logic       stop;
        klen   = (klen_cfg > 4'(MAX_KEY)) ? 4'(MAX_KEY) : klen_cfg;
        cap    = (cap_cfg == 9'd0) ? 9'd1 : ((cap_cfg > CAPACITY_MAX) ? CAPACITY_MAX : cap_cfg);
        stop   = (ch == 8'd0) || fin;
        step_n = 0;
        if (ch != 8'd0) begin
            if (p_mode == MODE_SEG) begin
                if (ch == CHAR_CR || ch == CHAR_LF) begin
                    add_result(KIND_NOT_FOUND, 8'd0, 9'd0, 1'b0);
                    p_mode = MODE_DONE;
                end else begin
                    p_mode = MODE_MATCH;
                    p_kpos = 4'd0;
                end
            end
            if (p_mode == MODE_MATCH) begin
                if (p_kpos < klen) begin
                    // key compare comes before the separator meaning of '&'
                    if (ch == key_cfg[8*p_kpos[2:0] +: 8]) p_kpos = p_kpos + 4'd1;
                    else if (ch == CHAR_AMP) begin
                        p_mode = MODE_SEG;
                        p_kpos = 4'd0;
                    end else p_mode = MODE_SKIP;
                end else if (ch == CHAR_EQUALS) begin
                    p_mode  = MODE_VALUE;
                    p_esc   = 2'd0;
                    p_count = 9'd0;
                    p_ovf   = 1'b0;
                end else if (ch == CHAR_AMP) begin
                    p_mode = MODE_SEG;
                    p_kpos = 4'd0;
                end else p_mode = MODE_SKIP;
            end else if (p_mode == MODE_SKIP) begin
                if (ch == CHAR_AMP) begin
                    p_mode = MODE_SEG;
                    p_kpos = 4'd0;
                end
            end else if (p_mode == MODE_VALUE) begin
                if (ch == CHAR_AMP) begin
                    add_result(KIND_FOUND, 8'd0, p_count + 9'd1, p_ovf);
                    p_mode = MODE_DONE;
                end else if (p_count >= cap - 9'd1) begin
                    p_ovf = 1'b1;
                end else if (p_esc == 2'd1) begin
                    p_hi  = nibble_of(ch);
                    p_esc = 2'd2;
                end else if (p_esc == 2'd2) begin
                    add_result(KIND_BYTE, {p_hi, nibble_of(ch)}, 9'd0, 1'b0);
                    p_count = p_count + 9'd1;
                    p_esc   = 2'd0;
                end else if (ch == CHAR_PERCENT) begin
                    p_esc = 2'd1;
                end else begin
                    add_result(KIND_BYTE, (ch == CHAR_PLUS) ? CHAR_SPACE : ch, 9'd0, 1'b0);
                    p_count = p_count + 9'd1;
                end
            end
        end
        if (stop) begin
            if (p_mode == MODE_VALUE) add_result(KIND_FOUND, 8'd0, p_count + 9'd1, p_ovf);
            else if (p_mode != MODE_DONE) add_result(KIND_NOT_FOUND, 8'd0, 9'd0, 1'b0);
            p_mode  = MODE_SEG;
            p_kpos  = 4'd0;
            p_esc   = 2'd0;
            p_hi    = 4'd0;
            p_count = 9'd0;
            p_ovf   = 1'b0;
        end
        if (step_n > 0) step_out[step_n-1].last = 1'b1;
    endfunction

    function automatic row_t byte_row(input logic [7:0] ch, input logic fin);
        row_t r;
        r = '0;
        r.beat.ch  = ch;
        r.beat.fin = fin;
        return r;
    endfunction

    // a beat whose single result is written out by hand
    function automatic row_t hit_row(input logic [7:0] ch, input logic fin, input logic [1:0] kind,
                                     input logic [7:0] data, input logic [8:0] len,
                                     input logic trunc);
        row_t r;
        r = byte_row(ch, fin);
        r.beat.typed          = 1'b1;
        r.beat.want.kind      = kind;
        r.beat.want.data      = data;
        r.beat.want.length    = len;
        r.beat.want.truncated = trunc;
        r.beat.want.last      = 1'b1;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [63:0] val);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_KEY_CHARS:    key_cfg  = val;
            REG_KEY_LENGTH:   klen_cfg = val[3:0];
            REG_OUT_CAPACITY: cap_cfg  = val[8:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // drain everything queued, then give the parser time to settle
    task automatic wait_idle();
        int spins;
        spins = 0;
        while ((beat_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
               && spins < IDLE_BOUND) begin
            @(posedge aclk);
            spins++;
        end
        if (awaited_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results still awaited, expected none", $time,
                     awaited_results.size());
            awaited_results.delete();
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_beat(input logic [7:0] ch, input logic fin);
        beat_t b;
        b = '0;
        b.ch  = ch;
        b.fin = fin;
        beat_q.push_back(b);
        n_queued++;
    endtask

    // one query string: mostly key=value segments, sometimes raw noise
    task automatic make_query();
        logic [7:0] q [$];
        logic [7:0] c;
        logic [3:0] v;
        int         nseg, vlen, r, klen_eff, cap_eff, n, j;
        logic       fin_on_char;
        klen_eff = (klen_cfg > 4'(MAX_KEY)) ? MAX_KEY : int'(klen_cfg);
        cap_eff  = (cap_cfg == 9'd0) ? 1 : ((cap_cfg > CAPACITY_MAX) ? 256 : int'(cap_cfg));
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 10);
            for (j = 0; j < n; j++) q.push_back(8'($urandom_range(1, 255)));
        end else begin
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0) q.push_back(CHAR_AMP);
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                end else begin
                    if (r < 65) begin
                        for (j = 0; j < klen_eff; j++) q.push_back(key_cfg[8*j +: 8]);
                    end else if (r < 85) begin
                        // near miss: a key prefix then a stray letter
                        n = $urandom_range(0, klen_eff);
                        for (j = 0; j < n; j++) q.push_back(key_cfg[8*j +: 8]);
                        q.push_back(8'h61 + 8'($urandom_range(0, 3)));
                    end else begin
                        n = $urandom_range(0, 4);
                        for (j = 0; j < n; j++) q.push_back(8'h61 + 8'($urandom_range(0, 3)));
                    end
                    if ($urandom_range(0, 99) < 85) begin
                        q.push_back(CHAR_EQUALS);
                        vlen = ($urandom_range(0, 9) == 0)
                             ? $urandom_range(0, (cap_eff + 3 > 40) ? 40 : cap_eff + 3)
                             : $urandom_range(0, 8);
                        for (j = 0; j < vlen; j++) begin
                            r = $urandom_range(0, 99);
                            if (r < 45) q.push_back(8'h61 + 8'($urandom_range(0, 25)));
                            else if (r < 55) q.push_back(CHAR_PLUS);
                            else if (r < 75) begin
                                q.push_back(CHAR_PERCENT);
                                repeat (2) begin
                                    v = 4'($urandom_range(0, 15));
                                    if ($urandom_range(0, 99) < 15) c = 8'($urandom_range(1, 255));
                                    else if (v < 4'd10) c = 8'h30 + {4'd0, v};
                                    else c = ($urandom_range(0, 1) ? 8'h61 : 8'h41)
                                           + {4'd0, v} - 8'd10;
                                    q.push_back(c);
                                end
                            end else q.push_back(8'($urandom_range(1, 255)));
                        end
                    end
                end
            end
        end
        // now and then leave an escape open at the end
        if ($urandom_range(0, 9) == 0) q.push_back(CHAR_PERCENT);
        fin_on_char = (q.size() != 0) && ($urandom_range(0, 1) == 1);
        for (j = 0; j < q.size(); j++) push_beat(q[j], fin_on_char && (j == q.size() - 1));
        if (!fin_on_char) push_beat(8'h00, 1'($urandom_range(0, 1)));
    endtask

    // sender: a beat stays on the bus until taken
    initial begin
        beat_t b;
        forever begin
            @(negedge aclk);
            if (!s_tvalid || s_taken) begin
                if (aresetn && beat_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
                    b = beat_q.pop_front();
                    cur_beat = b;
                    s_tvalid <= 1'b1;
                    s_tdata  <= b.ch;
                    s_tlast  <= b.fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    always @(posedge aclk) begin
        result_t w;
        if (aresetn) begin
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                decode_beat(s_tdata, s_tlast);
                n_beats++;
                if (cur_beat.typed) awaited_results.push_back(cur_beat.want);
                else for (int i = 0; i < step_n; i++) awaited_results.push_back(step_out[i]);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat kind %0d data %h with nothing expected",
                                 $time, m_tuser, m_tdata);
                end else begin
                    w = awaited_results.pop_front();
                    n_results++;
                    if (w.kind == KIND_FOUND) n_found++;
                    if (w.kind == KIND_NOT_FOUND) n_not_found++;
                    cmp_field("kind", 32'(w.kind), 32'(m_tuser));
                    cmp_field("byte", 32'(w.data), 32'(m_tdata[7:0]));
                    cmp_field("length", 32'(w.length), 32'(m_tdata[16:8]));
                    cmp_field("truncated", 32'(w.truncated), 32'(m_tdata[17]));
                    cmp_field("pad", 32'd0, 32'(m_tdata[23:18]));
                    cmp_field("last", 32'(w.last), 32'(m_tlast));
                end
            end
        end else begin
            s_taken = 1'b0;
        end
    end

    initial begin
        logic [63:0] key_new;
        logic [7:0]  c;
        logic [3:0]  klen_new;
        logic [8:0]  cap_new;
        int          start;

        dir_table = '{
            // empty key and capacity 64 after reset
            hit_row(CHAR_LF, 1'b0, KIND_NOT_FOUND, 8'd0, 9'd0, 1'b0),   // line break at segment start gives not found
            byte_row(8'hff, 1'b1),                                        // ignored after verdict
            byte_row(CHAR_EQUALS, 1'b0),                                  // empty key matches
            hit_row(CHAR_PLUS, 1'b0, KIND_BYTE, CHAR_SPACE, 9'd0, 1'b0),
            byte_row(CHAR_PERCENT, 1'b0),
            byte_row("F", 1'b0),
            hit_row("f", 1'b0, KIND_BYTE, 8'hff, 9'd0, 1'b0),
            byte_row(CHAR_PERCENT, 1'b0),
            byte_row("g", 1'b0),                                          // bad hex digit is 0
            hit_row("1", 1'b0, KIND_BYTE, 8'h01, 9'd0, 1'b0),
            byte_row(CHAR_PERCENT, 1'b0),                                 // escape cut by '&'
            hit_row(CHAR_AMP, 1'b1, KIND_FOUND, 8'd0, 9'd4, 1'b0),
            // key "ab", room for the terminator only
            cfg_row(REG_KEY_CHARS, 64'h6261),
            cfg_row(REG_KEY_LENGTH, 64'd2),
            cfg_row(REG_OUT_CAPACITY, 64'd1),
            byte_row("a", 1'b0),
            byte_row(CHAR_AMP, 1'b0),                                     // mismatch on separator
            byte_row("a", 1'b0),
            byte_row("b", 1'b0),
            byte_row(CHAR_EQUALS, 1'b0),
            hit_row(CHAR_PERCENT, 1'b1, KIND_FOUND, 8'd0, 9'd1, 1'b1),    // full, so truncated
            hit_row(CHAR_CR, 1'b1, KIND_NOT_FOUND, 8'd0, 9'd0, 1'b0),
            byte_row("a", 1'b0),
            hit_row(8'h00, 1'b0, KIND_NOT_FOUND, 8'd0, 9'd0, 1'b0),       // ends before a match
            // oversized capacity and key length, then length cut mid-string
            cfg_row(REG_OUT_CAPACITY, 64'd511),
            cfg_row(REG_KEY_LENGTH, 64'd15),
            byte_row("a", 1'b0),
            byte_row("b", 1'b0),
            cfg_row(REG_KEY_LENGTH, 64'd2),
            byte_row(CHAR_EQUALS, 1'b0),
            hit_row(8'h80, 1'b0, KIND_BYTE, 8'h80, 9'd0, 1'b0),
            hit_row(CHAR_AMP, 1'b1, KIND_FOUND, 8'd0, 9'd2, 1'b0)
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NROWS; i++) begin
            if (dir_table[i].is_cfg) begin
                wait_idle();
                write_reg(dir_table[i].idx, dir_table[i].val);
            end else begin
                beat_q.push_back(dir_table[i].beat);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            calm = 1'b0;
            key_new = 64'd0;
            for (int j = 0; j < MAX_KEY; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CHAR_AMP) c = 8'ha6;
                end else begin
                    c = 8'h61 + 8'($urandom_range(0, 2));
                end
                key_new[8*j +: 8] = c;
            end
            if (phase == 7) key_new[15:8] = 8'h00;     // a zero key byte can never match
            if (phase == 0) klen_new = 4'd0;
            else if (phase == 4) klen_new = 4'($urandom_range(9, 15));
            else if (phase == 5 || phase == 8) klen_new = 4'd8;
            else klen_new = 4'($urandom_range(0, 8));
            case (phase % 5)
                0:       cap_new = CAPACITY_MAX;
                1:       cap_new = 9'($urandom_range(1, 6));
                2:       cap_new = 9'd0;
                3:       cap_new = 9'($urandom_range(257, 511));
                default: cap_new = 9'($urandom_range(1, 40));
            endcase
            write_reg(REG_KEY_CHARS, key_new);
            write_reg(REG_KEY_LENGTH, {60'd0, klen_new});
            write_reg(REG_OUT_CAPACITY, {55'd0, cap_new});
            calm  = (phase == CALM_PHASE);
            start = n_queued;
            if (phase == 0) begin
                // long value while the receiver holds off, so the result queue backs up
                hold_req = 1'b1;
                push_beat(CHAR_EQUALS, 1'b0);
                repeat (120) push_beat(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                push_beat(8'h00, 1'b0);
            end
            while (n_queued - start < PHASE_BEATS) make_query();
        end

        wait_idle();
        $display("%0d beats driven across %0d register writes", n_beats, n_writes);
        $display("%0d results checked: %0d found, %0d not found", n_results, n_found, n_not_found);
        if (errors == 0) begin
            $display("query_argument_extract_decode test passed");
        end else begin
            $display("query_argument_extract_decode test failed");
        end
        $finish;
    end

endmodule
